// File: rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg
// Shared constants and the sequencer state type for the interval room
// allocator.
// ----------------------------------------------------------------------------
package ira_pkg;

	localparam int MAX_ROOMS_DEF = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int FIELD_W       = 32;
	localparam int STAMP_W       = 32;
	localparam int OUT_W         = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

endpackage

// File: rtl/interval_room_allocator.sv
// ----------------------------------------------------------------------------
// interval_room_allocator
// Greedy interval partitioning: assigns each reservation to the free room
// that fell free earliest, opens a new room, or flags overflow.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one reservation per transaction: arrival and departure in
//   s_tdata, the first-of-batch flag in s_tuser. Arrivals within a batch are
//   expected nondecreasing; a decrease is reported but the request is still
//   handled. m_* returns one result per request: room number and room count
//   in m_tdata, the new-room, overflow and order-error flags in m_tuser.
//   Each request scans the opened rooms one entry per cycle through the
//   registered read port of the room RAM, with one compare unit picking the
//   earliest departure (oldest use on ties). A request is accepted in IDLE,
//   scanned in SCAN and written back in COMMIT; the next request can be
//   accepted the cycle after the result is registered.
//   A finished result waits in the output register while the next request
//   is accepted and scanned; if the receiver still stalls when that request
//   is done, the block holds before writing it back. Reset clears the room
//   count, the use stamp and the last arrival; the RAM needs no clearing
//   since only opened rooms are ever read.
// ----------------------------------------------------------------------------
module interval_room_allocator
	import ira_pkg::*;
#(
	parameter int MAX_ROOMS = MAX_ROOMS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*FIELD_W-1:0] s_tdata,  // arrival_day, departure_day
	input  logic                 s_tuser,  // batch_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // room_number, rooms_open, zero pad
	output logic [2:0]           m_tuser   // opened_new, overflow, order_error
);

	localparam int TW    = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
	localparam int IDX_W = $clog2(MAX_ROOMS);
	localparam int CNT_W = $clog2(MAX_ROOMS + 1);
	localparam int RAM_W = STAMP_W + TW;

	state_t state_q, state_d;

	logic [TW-1:0]      arr_q, dep_q, last_arr_q;
	logic [CNT_W-1:0]   count_q, scan_q;
	logic [STAMP_W-1:0] seq_q;
	logic               oerr_q;

	logic               found_q;
	logic [IDX_W-1:0]   best_q;
	logic [TW-1:0]      best_end_q;
	logic [STAMP_W-1:0] best_use_q;

	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [RAM_W-1:0]   rd_data;
	logic [TW-1:0]      rd_end;
	logic [STAMP_W-1:0] rd_use;

	logic               rd_en, commit_go, scan_done, take, ram_we, has_room;
	logic [IDX_W-1:0]   wr_idx;
	logic [CNT_W-1:0]   room_sel;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   room_q, rooms_q;
	logic               new_q, ovf_q, oerr_out_q;

	logic               accept;
	logic               in_start;
	logic [TW-1:0]      in_arr, in_dep;

	assign in_arr   = s_tdata[TW-1:0];
	assign in_dep   = s_tdata[FIELD_W +: TW];
	assign in_start = s_tuser;
	assign accept   = s_tvalid && s_tready;

	assign rd_end = rd_data[TW-1:0];
	assign rd_use = rd_data[TW +: STAMP_W];

	assign has_room  = (count_q < CNT_W'(MAX_ROOMS));
	assign scan_done = (scan_q >= count_q) && !rd_vld_s1;
	assign wr_idx    = found_q ? best_q : count_q[IDX_W-1:0];
	assign room_sel  = CNT_W'(wr_idx) + CNT_W'(1);

	// candidate beats current best: earlier departure, then older use stamp
	assign take = rd_vld_s1 && (rd_end < arr_q) &&
		(!found_q || (rd_end < best_end_q) ||
		 ((rd_end == best_end_q) && (rd_use < best_use_q)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		commit_go = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_SCAN:   rd_en     = (scan_q < count_q);
			ST_COMMIT: commit_go = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign ram_we = commit_go && (found_q || has_room);

	ira_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_ROOMS)
	) u_rooms (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx),
		.wdata ({seq_q, dep_q}),
		.re    (rd_en),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			seq_q      <= '0;
			last_arr_q <= '0;
			scan_q     <= '0;
			found_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				last_arr_q <= in_arr;
				scan_q     <= '0;
				found_q    <= 1'b0;
				if (in_start) begin
					count_q <= '0;
					seq_q   <= '0;
				end
			end
			if (rd_en) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (ram_we) begin
				seq_q <= seq_q + STAMP_W'(1);
				if (!found_q) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (commit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (accept) begin
			arr_q  <= in_arr;
			dep_q  <= in_dep;
			oerr_q <= !in_start && (in_arr < last_arr_q);
		end
		if (take) begin
			best_q     <= rd_idx_s1;
			best_end_q <= rd_end;
			best_use_q <= rd_use;
		end
		if (commit_go) begin
			oerr_out_q <= oerr_q;
			if (found_q) begin
				room_q  <= OUT_W'(room_sel);
				new_q   <= 1'b0;
				ovf_q   <= 1'b0;
				rooms_q <= OUT_W'(count_q);
			end else if (has_room) begin
				room_q  <= OUT_W'(room_sel);
				new_q   <= 1'b1;
				ovf_q   <= 1'b0;
				rooms_q <= OUT_W'(count_q + CNT_W'(1));
			end else begin
				room_q  <= '0;
				new_q   <= 1'b0;
				ovf_q   <= 1'b1;
				rooms_q <= OUT_W'(count_q);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - 2*OUT_W){1'b0}}, rooms_q, room_q};
	assign m_tuser  = {oerr_out_q, ovf_q, new_q};

	// room count never passes the number of rooms
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ROOMS))
		else $error("room count above limit");

	// reads only touch opened rooms
	a_read_opened: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (scan_q < count_q) && (state_q == ST_SCAN))
		else $error("read beyond opened rooms");

	// a room write always yields a result in the next cycle
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> m_tvalid_q)
		else $error("room written without result");

	// overflow results carry no room and no new-room flag
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && ovf_q) |-> (room_q == '0) && !new_q)
		else $error("overflow result with a room");

	// no input transaction while a scan pipeline read is in flight
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> !s_tready)
		else $error("input taken during scan");

endmodule

// File: rtl/ira_ram.sv
// ----------------------------------------------------------------------------
// ira_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ira_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
